>>> rtl/disjoint_set_union_find_core_macros.svh
// Assertion macros shared by the union-find core modules.
`ifndef DISJOINT_SET_UNION_FIND_CORE_MACROS_SVH
`define DISJOINT_SET_UNION_FIND_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSUF_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSUF_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dsuf_pkg.sv
// Types, constants and the microcode store of the union-find core.
`timescale 1ns / 1ps

package dsuf_pkg;

    localparam int NODE_W    = 10;
    localparam int SIZE_W    = 11;
    localparam int NODE_SPAN = 1 << NODE_W;
    localparam int STEP_W    = 5;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] root;
        logic [SIZE_W-1:0] set_size;
        logic              merged;
    } rsp_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_RD_PAR,
        OP_FOLLOW,
        OP_RESTART,
        OP_COMPRESS,
        OP_SAVE_A,
        OP_RD_CNT_B,
        OP_RD_CNT_A,
        OP_MERGE,
        OP_CAPTURE,
        OP_LONE,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_A_OUT,
        COND_NOT_ROOT,
        COND_AT_ROOT,
        COND_NO_MERGE,
        COND_SAME,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        step_t  target;
    } uword_t;

    typedef struct packed {
        logic is_root;
        logic at_root;
        logic a_out;
        logic no_merge;
        logic same_root;
        logic clearing;
    } status_t;

    localparam step_t ST_WAIT   = 5'd0;
    localparam step_t ST_CHK_A  = 5'd1;
    localparam step_t ST_WALK_A = 5'd2;
    localparam step_t ST_HOP_A  = 5'd3;
    localparam step_t ST_RST_A  = 5'd4;
    localparam step_t ST_CRD_A  = 5'd5;
    localparam step_t ST_CWR_A  = 5'd6;
    localparam step_t ST_SAVE_A = 5'd7;
    localparam step_t ST_WALK_B = 5'd8;
    localparam step_t ST_HOP_B  = 5'd9;
    localparam step_t ST_RST_B  = 5'd10;
    localparam step_t ST_CRD_B  = 5'd11;
    localparam step_t ST_CWR_B  = 5'd12;
    localparam step_t ST_CMP_R  = 5'd13;
    localparam step_t ST_RD_A   = 5'd14;
    localparam step_t ST_MERGE  = 5'd15;
    localparam step_t ST_FIN    = 5'd16;
    localparam step_t ST_CAPT   = 5'd17;
    localparam step_t ST_EMIT   = 5'd18;
    localparam step_t ST_HOLD   = 5'd19;
    localparam step_t ST_LONE   = 5'd20;

    // A step jumps to its target when its condition holds, else falls through.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            ST_WAIT:   w = '{OP_NOP,      COND_NO_REQ,   ST_WAIT};
            ST_CHK_A:  w = '{OP_NOP,      COND_A_OUT,    ST_LONE};
            ST_WALK_A: w = '{OP_RD_PAR,   COND_NEVER,    ST_WAIT};
            ST_HOP_A:  w = '{OP_FOLLOW,   COND_NOT_ROOT, ST_WALK_A};
            ST_RST_A:  w = '{OP_RESTART,  COND_NEVER,    ST_WAIT};
            ST_CRD_A:  w = '{OP_RD_PAR,   COND_AT_ROOT,  ST_SAVE_A};
            ST_CWR_A:  w = '{OP_COMPRESS, COND_ALWAYS,   ST_CRD_A};
            ST_SAVE_A: w = '{OP_SAVE_A,   COND_NO_MERGE, ST_FIN};
            ST_WALK_B: w = '{OP_RD_PAR,   COND_NEVER,    ST_WAIT};
            ST_HOP_B:  w = '{OP_FOLLOW,   COND_NOT_ROOT, ST_WALK_B};
            ST_RST_B:  w = '{OP_RESTART,  COND_NEVER,    ST_WAIT};
            ST_CRD_B:  w = '{OP_RD_PAR,   COND_AT_ROOT,  ST_CMP_R};
            ST_CWR_B:  w = '{OP_COMPRESS, COND_ALWAYS,   ST_CRD_B};
            ST_CMP_R:  w = '{OP_RD_CNT_B, COND_SAME,     ST_FIN};
            ST_RD_A:   w = '{OP_RD_CNT_A, COND_NEVER,    ST_WAIT};
            ST_MERGE:  w = '{OP_MERGE,    COND_NEVER,    ST_WAIT};
            ST_FIN:    w = '{OP_RD_CNT_A, COND_NEVER,    ST_WAIT};
            ST_CAPT:   w = '{OP_CAPTURE,  COND_NEVER,    ST_WAIT};
            ST_EMIT:   w = '{OP_EMIT,     COND_OUT_FREE, ST_WAIT};
            ST_HOLD:   w = '{OP_NOP,      COND_ALWAYS,   ST_EMIT};
            ST_LONE:   w = '{OP_LONE,     COND_ALWAYS,   ST_EMIT};
            default:   w = '{OP_NOP,      COND_ALWAYS,   ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/dsuf_sequencer.sv
// Step counter, microcode store lookup and jump condition select.
`timescale 1ns / 1ps
`include "disjoint_set_union_find_core_macros.svh"

module dsuf_sequencer
    import dsuf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    input  logic    take,
    input  logic    out_free,
    output uword_t  uw,
    output logic    idle
);

    step_t step_reg;
    step_t step_next;
    logic  jump;

    assign uw   = ucode(step_reg);
    assign idle = (step_reg == ST_WAIT);

    always_comb
    begin
        case (uw.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_REQ:   jump = !take;
            COND_A_OUT:    jump = status.a_out;
            COND_NOT_ROOT: jump = !status.is_root;
            COND_AT_ROOT:  jump = status.at_root;
            COND_NO_MERGE: jump = status.no_merge;
            COND_SAME:     jump = status.same_root;
            COND_OUT_FREE: jump = out_free;
            default:       jump = 1'b1;
        endcase
        step_next = jump ? uw.target : step_t'(step_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    `DSUF_CHECK_NEXT(a_take_starts_program, take, step_reg == ST_CHK_A, "request did not start the program")
    `DSUF_CHECK_NEXT(a_emit_returns, (uw.op == OP_EMIT) && out_free, step_reg == ST_WAIT, "emit did not return to wait")

endmodule

>>> rtl/dsuf_datapath.sv
// Parent and size memories, walk registers and the clearing pass after reset.
`timescale 1ns / 1ps
`include "disjoint_set_union_find_core_macros.svh"

module dsuf_datapath
    import dsuf_pkg::*;
#(
    parameter int NUM_ELEMENTS = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  req_t    req,
    input  logic    take,
    input  uword_t  uw,
    output status_t status,
    output rsp_t    result
);

    // Only indices below the node field's span can ever be addressed.
    localparam int DEPTH = (NUM_ELEMENTS < NODE_SPAN) ? NUM_ELEMENTS : NODE_SPAN;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    idx_t parent_mem [DEPTH];
    cnt_t count_mem  [DEPTH];

    logic              clr_active_reg;
    idx_t              clr_idx_reg;

    logic [NODE_W-1:0] a_node_reg;
    logic              a_out_reg;
    logic              no_merge_reg;
    idx_t              b_idx_reg;
    idx_t              start_reg;
    idx_t              cur_reg;
    idx_t              root_reg;
    idx_t              root_a_reg;
    cnt_t              cnt_b_reg;
    idx_t              par_rdata_reg;
    cnt_t              cnt_rdata_reg;
    logic [NODE_W-1:0] res_root_reg;
    logic [SIZE_W-1:0] res_size_reg;
    logic              merged_reg;

    logic              par_we;
    idx_t              par_waddr;
    idx_t              par_wdata;
    logic              cnt_we;
    idx_t              cnt_waddr;
    cnt_t              cnt_wdata;
    logic              cnt_re;
    idx_t              cnt_raddr;
    logic              a_in;
    logic              b_in;

    assign a_in = int'({1'b0, req.node_a}) < NUM_ELEMENTS;
    assign b_in = int'({1'b0, req.node_b}) < NUM_ELEMENTS;

    // The clearing pass owns both write ports until every entry is restored.
    always_comb
    begin
        par_we    = clr_active_reg || (uw.op == OP_COMPRESS) || (uw.op == OP_MERGE);
        par_waddr = clr_active_reg ? clr_idx_reg :
                    (uw.op == OP_COMPRESS) ? cur_reg : root_reg;
        par_wdata = clr_active_reg ? clr_idx_reg :
                    (uw.op == OP_COMPRESS) ? root_reg : root_a_reg;
        cnt_we    = clr_active_reg || (uw.op == OP_MERGE);
        cnt_waddr = clr_active_reg ? clr_idx_reg : root_a_reg;
        cnt_wdata = clr_active_reg ? cnt_t'(1) : cnt_t'(cnt_rdata_reg + cnt_b_reg);
        cnt_re    = (uw.op == OP_RD_CNT_B) || (uw.op == OP_RD_CNT_A);
        cnt_raddr = (uw.op == OP_RD_CNT_B) ? root_reg : root_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            parent_mem[par_waddr] <= par_wdata;
        end
        if (uw.op == OP_RD_PAR)
        begin
            par_rdata_reg <= parent_mem[cur_reg];
        end
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rdata_reg <= count_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_idx_reg <= idx_t'(clr_idx_reg + 1'b1);
            if (clr_idx_reg == idx_t'(DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_node_reg   <= req.node_a;
            a_out_reg    <= !a_in;
            no_merge_reg <= !req.cmd || !b_in;
            b_idx_reg    <= req.node_b[IDX_W-1:0];
            start_reg    <= req.node_a[IDX_W-1:0];
            cur_reg      <= req.node_a[IDX_W-1:0];
            merged_reg   <= 1'b0;
        end
        else
        begin
            case (uw.op)
                OP_FOLLOW:
                begin
                    cur_reg  <= par_rdata_reg;
                    root_reg <= cur_reg;
                end
                OP_RESTART:
                begin
                    cur_reg <= start_reg;
                end
                OP_COMPRESS:
                begin
                    cur_reg <= par_rdata_reg;
                end
                OP_SAVE_A:
                begin
                    root_a_reg <= root_reg;
                    start_reg  <= b_idx_reg;
                    cur_reg    <= b_idx_reg;
                end
                OP_RD_CNT_A:
                begin
                    cnt_b_reg <= cnt_rdata_reg;
                end
                OP_MERGE:
                begin
                    merged_reg <= 1'b1;
                end
                OP_CAPTURE:
                begin
                    res_root_reg <= NODE_W'(root_a_reg);
                    res_size_reg <= SIZE_W'(cnt_rdata_reg);
                end
                OP_LONE:
                begin
                    res_root_reg <= a_node_reg;
                    res_size_reg <= SIZE_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.is_root   = (par_rdata_reg == cur_reg);
    assign status.at_root   = (cur_reg == root_reg);
    assign status.a_out     = a_out_reg;
    assign status.no_merge  = no_merge_reg;
    assign status.same_root = (root_reg == root_a_reg);
    assign status.clearing  = clr_active_reg;

    assign result.root     = res_root_reg;
    assign result.set_size = res_size_reg;
    assign result.merged   = merged_reg;

    `DSUF_CHECK_NOW(a_merge_distinct, uw.op == OP_MERGE, root_reg != root_a_reg, "merge of a root with itself")
    `DSUF_CHECK_NOW(a_compress_off_root, uw.op == OP_COMPRESS, cur_reg != root_reg, "root relinked during compression")

endmodule

>>> rtl/disjoint_set_union_find_core.sv
// Top level of the union-find core: request handshake, sequencer, datapath, result register.
`timescale 1ns / 1ps
`include "disjoint_set_union_find_core_macros.svh"

// Usage: a request (cmd, node_a, node_b) is taken when req_valid is high and req_stall low;
// cmd 0 finds node_a's root, cmd 1 merges the sets of node_a and node_b. Every request gives
// exactly one response (root, set_size, merged) on rsp, taken when rsp_valid is high and
// rsp_stall low. One request is worked on at a time by a microcoded sequencer; each parent
// link visited takes a memory read step and a follow step on the walk to the root, and a
// read step and a write step on the compression pass. A node_a outside the set skips the
// walk and is answered as a set of its own, of size 1. The next request is accepted in the
// cycle after the response is loaded, even if the receiver still stalls it; a stalled
// response holds and the sequencer waits only when a second response is ready. After reset,
// the block restores every parent link and set size in a clearing pass over min(NUM_ELEMENTS,
// 1024) entries, one entry a cycle, with req_stall held high throughout.
module disjoint_set_union_find_core
    import dsuf_pkg::*;
#(
    parameter int NUM_ELEMENTS = 1024
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    uword_t  uw;
    status_t status;
    rsp_t    result;
    logic    seq_idle;
    logic    take;
    logic    out_free;
    logic    rsp_valid_reg;
    rsp_t    rsp_reg;

    assign req_stall = !seq_idle || status.clearing;
    assign take      = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    dsuf_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .take     (take),
        .out_free (out_free),
        .uw       (uw),
        .idle     (seq_idle)
    );

    dsuf_datapath #(
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .take   (take),
        .uw     (uw),
        .status (status),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((uw.op == OP_EMIT) && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((uw.op == OP_EMIT) && out_free)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `DSUF_CHECK_NOW(a_rsp_from_emit, $rose(rsp_valid_reg), $past(uw.op == OP_EMIT),
                    "response raised outside the emit step")

endmodule

>>> verif/disjoint_set_union_find_core_tb.sv
// Self-checking testbench for the union-find core, with its own set-forest predictor.
`timescale 1ns / 1ps

module disjoint_set_union_find_core_tb
    import dsuf_pkg::*;
();

    localparam int NUM_NODES = 1024;
    localparam int SIZE_CAP  = (1 << SIZE_W) - 1;

    localparam logic CMD_FIND  = 1'b0;
    localparam logic CMD_MERGE = 1'b1;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Shadow copy of the forest: parent of each node and set size at each root.
    logic [NODE_W-1:0] link_tbl [NUM_NODES];
    int unsigned       count_tbl [NUM_NODES];

    rsp_t pending_rsp [$];
    int   error_count;
    bit   calm;

    disjoint_set_union_find_core #(
        .NUM_ELEMENTS (NUM_NODES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Walks to the root, then points every node on the path straight at it.
    function automatic int unsigned trace_root(input int unsigned x);
        int unsigned r;
        int unsigned n;
        int unsigned nxt;
        int unsigned hops;
        r = x;
        hops = 0;
        while (link_tbl[r] != r && hops < NUM_NODES)
        begin
            r = link_tbl[r];
            hops++;
        end
        n = x;
        hops = 0;
        while (n != r && hops < NUM_NODES)
        begin
            nxt = link_tbl[n];
            link_tbl[n] = r[NODE_W-1:0];
            n = nxt;
            hops++;
        end
        return r;
    endfunction

    function automatic rsp_t predict_response(input req_t item);
        int unsigned ra;
        int unsigned rb;
        int unsigned size;
        logic        joined;
        rsp_t        res;
        joined = 1'b0;
        if (item.node_a >= NUM_NODES)
        begin
            ra = item.node_a;
            size = 1;
        end
        else
        begin
            ra = trace_root(item.node_a);
            if (item.cmd == CMD_MERGE && item.node_b < NUM_NODES)
            begin
                rb = trace_root(item.node_b);
                if (rb != ra)
                begin
                    count_tbl[ra] += count_tbl[rb];
                    link_tbl[rb] = ra[NODE_W-1:0];
                    joined = 1'b1;
                end
            end
            size = count_tbl[ra];
        end
        if (size > SIZE_CAP)
            size = SIZE_CAP;
        res.root     = ra[NODE_W-1:0];
        res.set_size = size[SIZE_W-1:0];
        res.merged   = joined;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // Offers one request, with an optional gap in front, and records its expected response.
    task automatic send_request(input logic op, input int unsigned a, input int unsigned b);
        req_t item;
        int   gap;
        item.cmd    = op;
        item.node_a = a[NODE_W-1:0];
        item.node_b = b[NODE_W-1:0];
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_rsp.push_back(predict_response(item));
    endtask

    task automatic wait_drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        int k;
        send_request(CMD_FIND, 0, 0);
        send_request(CMD_FIND, 1023, 1023);
        send_request(CMD_MERGE, 0, 1023);
        send_request(CMD_MERGE, 1023, 0);
        send_request(CMD_MERGE, 1023, 1023);
        send_request(CMD_FIND, 1023, 0);
        // Each merge hangs the previous root under the next node, giving a long chain.
        for (k = 5; k <= 12; k++)
            send_request(CMD_MERGE, k, k - 1);
        send_request(CMD_FIND, 4, 1023);
        send_request(CMD_FIND, 4, 0);
        send_request(CMD_MERGE, 4, 0);
        send_request(CMD_MERGE, 0, 4);
        send_request(CMD_FIND, 1023, 512);
        send_request(CMD_MERGE, 512, 511);
        send_request(CMD_MERGE, 511, 9);
        send_request(CMD_FIND, 512, 1023);
        wait_drain();
    endtask

    // Mostly merges within a narrow window so that sets and paths grow.
    task automatic test_local_sets(input int count);
        int i;
        int unsigned a;
        int unsigned b;
        for (i = 0; i < count; i++)
        begin
            a = $urandom_range(64, 127);
            b = $urandom_range(64, 127);
            if ($urandom_range(0, 9) < 6)
                send_request(CMD_MERGE, a, b);
            else
                send_request(CMD_FIND, a, $urandom_range(0, NUM_NODES - 1));
        end
        wait_drain();
    endtask

    task automatic test_wide_random(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_request(logic'($urandom_range(0, 1)), $urandom_range(0, NUM_NODES - 1),
                         $urandom_range(0, NUM_NODES - 1));
        wait_drain();
    endtask

    // Merges each node, taken in a random order, with a node at or before it in that order.
    task automatic test_merge_everything();
        int unsigned order [NUM_NODES];
        int unsigned tmp;
        int i;
        int j;
        for (i = 0; i < NUM_NODES; i++)
            order[i] = i;
        for (i = NUM_NODES - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < NUM_NODES; i++)
            send_request(CMD_MERGE, order[$urandom_range(0, i)], order[i]);
        wait_drain();
    endtask

    task automatic test_back_to_back(input int count);
        int i;
        calm = 1'b1;
        for (i = 0; i < count; i++)
            send_request(logic'($urandom_range(0, 1)), $urandom_range(0, NUM_NODES - 1),
                         $urandom_range(0, NUM_NODES - 1));
        wait_drain();
    endtask

    // Receiver side: stall in random bursts, with free stretches in between.
    initial
    begin : rsp_stall_gen
        int span;
        bit stall_on;
        rsp_stall = 1'b0;
        forever
        begin
            span = $urandom_range(1, 8);
            stall_on = ($urandom_range(0, 2) == 0);
            repeat (span)
            begin
                @(negedge clk);
                rsp_stall <= stall_on && !calm;
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch($sformatf("unexpected response root=%0d", rsp.root));
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.root !== want.root)
                    report_mismatch($sformatf("root %0d, expected %0d", rsp.root, want.root));
                if (rsp.set_size !== want.set_size)
                    report_mismatch($sformatf("set_size %0d, expected %0d",
                                              rsp.set_size, want.set_size));
                if (rsp.merged !== want.merged)
                    report_mismatch($sformatf("merged %0d, expected %0d",
                                              rsp.merged, want.merged));
            end
        end
    end

    initial
    begin : watchdog
        #(64'd200_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : main_seq
        int i;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        calm        = 1'b0;
        error_count = 0;
        for (i = 0; i < NUM_NODES; i++)
        begin
            link_tbl[i]  = i[NODE_W-1:0];
            count_tbl[i] = 1;
        end
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_local_sets(250);
        test_wide_random(150);
        test_merge_everything();
        test_back_to_back(60);

        repeat (64) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
